// ===== rtl/assert_macros.svh =====
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked at every edge outside reset
`define APD_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("assertion failed");

// checked at every edge, reset included
`define APD_ASSERT_ALWAYS(label, prop) \
	label: assert property (@(posedge clk) prop) \
		else $error("assertion failed");

`endif

// ===== rtl/apd_pkg.sv =====
`default_nettype none
package apd_pkg;

	typedef struct packed {
		logic [31:0] inst_power;
		logic [31:0] smooth_power;
	} in_t;

	typedef struct packed {
		logic        detected;
		logic        pulse_done;
		logic        pulse_forced;
		logic [47:0] pulse_first;
		logic [47:0] pulse_last;
		logic [31:0] pulse_peak;
		logic [31:0] floor_level;
	} out_t;

	localparam int CFG_IDX_BITS = 3;
	localparam int CFG_DATA_BITS = 32;

	localparam logic [CFG_IDX_BITS-1:0] CFG_TRIGGER_GAIN = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_RELEASE_GAIN = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_FLOOR_ALPHA  = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_HOLD_COUNT   = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_COUNT    = 3'd4;

	localparam logic [15:0] TRIGGER_GAIN_RST = 16'd2560;
	localparam logic [15:0] RELEASE_GAIN_RST = 16'd1792;
	localparam logic [31:0] FLOOR_ALPHA_RST  = 32'd8948;
	localparam logic [23:0] HOLD_COUNT_RST   = 24'd4800;
	localparam logic [23:0] MAX_COUNT_RST    = 24'd48000;

	localparam logic [23:0] HOLD_MIN = 24'd2;
	localparam logic [23:0] MAX_MIN  = 24'd1;

endpackage
`default_nettype wire

// ===== rtl/apd_mul.sv =====
`default_nettype none
module apd_mul (
	input  wire logic        clk,
	input  wire logic [31:0] a,
	input  wire logic [31:0] b,
	output logic      [63:0] p_q
);

	always_ff @(posedge clk) begin
		p_q <= 64'(a) * 64'(b);
	end

endmodule
`default_nettype wire

// ===== rtl/adaptive_pulse_detector.sv =====
`default_nettype none
// adaptive pulse detector
// input channel (in_valid / in_ready / in_data) carries one beat per sample:
// instantaneous and lowpassed power, both unsigned Q2.30. the output channel
// (out_valid / out_ready / out_data) returns exactly one beat per sample:
// detection flag, pulse-end record and the current noise floor.
// configuration is a plain write port (cfg_we, cfg_index, cfg_data); write it
// only while no sample is in flight.
// one 32x32 registered multiplier is shared under a small sequencer: a sample
// with a valid floor runs a floor update (three products, subtract, saturating
// add) and then a level test (two products and a compare) before the result
// register; the very first sample seeds the floor instead of updating it, and a
// sample in a running pulse skips the floor update. in_ready is high only while
// the sequencer is idle, so a new sample is taken only once the last is through.
// the result sits in an output register, so the next sample is accepted while
// a result waits; if the receiver stalls, the sequencer holds in its final
// step until the output register frees, and back pressure reaches in_ready.
// reset clears the mode, the floor, the indexes and the output valid, and
// loads the configuration registers with their defaults.
module adaptive_pulse_detector #(
	parameter int INDEX_BITS = 48
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire apd_pkg::in_t                        in_data,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output apd_pkg::out_t                            out_data,
	input  wire logic                                cfg_we,
	input  wire logic [apd_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  wire logic [apd_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

	typedef enum logic [3:0] {
		S_IDLE, S_MHI, S_MLO, S_MP, S_BASE, S_SUM, S_LLO, S_LHI, S_CMP
	} state_t;

	typedef enum logic [1:0] {
		M_IDLE   = 2'd0,
		M_ACTIVE = 2'd1,
		M_REARM  = 2'd2
	} mode_t;

	localparam logic [23:0] HOLD_MIN_C = apd_pkg::HOLD_MIN;
	localparam logic [23:0] MAX_MIN_C = apd_pkg::MAX_MIN;

	state_t state_q;
	mode_t  mode_q;

	logic [15:0] trigger_gain_q;
	logic [15:0] release_gain_q;
	logic [31:0] floor_alpha_q;
	logic [23:0] hold_count_q;
	logic [23:0] max_count_q;

	apd_pkg::in_t in_q;
	apd_pkg::out_t out_q;
	logic out_valid_q;

	logic [63:0] acc_q;
	logic        fv_q;
	logic [63:0] t_q;
	logic [63:0] base_q;
	logic [47:0] lo_q;
	logic        dmax_q;
	logic        hold_x_q;
	logic [INDEX_BITS-1:0] idx_q;
	logic [INDEX_BITS-1:0] start_q;
	logic [INDEX_BITS-1:0] above_q;
	logic [31:0] peak_q;

	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [63:0] p_q;
	logic [15:0] gain;
	logic [56:0] lvl;
	logic [56:0] pwr;
	logic        is_above;
	logic        is_below;
	logic [64:0] sum;
	logic [23:0] hold_eff;
	logic [23:0] max_eff;
	logic [INDEX_BITS-1:0] dist_start;
	logic [INDEX_BITS-1:0] dist_above;
	logic [INDEX_BITS-1:0] above_new;
	logic [31:0] peak_new;
	logic        out_free;
	apd_pkg::out_t rec;

	apd_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (p_q)
	);

	always_comb begin
		unique case (mode_q) inside
			M_ACTIVE, M_REARM: gain = release_gain_q;
			default:           gain = trigger_gain_q;
		endcase
	end

	always_comb begin
		case (state_q) inside
			S_MHI: begin
				mul_a = floor_alpha_q;
				mul_b = acc_q[63:32];
			end
			S_MLO: begin
				mul_a = floor_alpha_q;
				mul_b = acc_q[31:0];
			end
			S_MP, S_BASE: begin
				mul_a = floor_alpha_q;
				mul_b = in_q.smooth_power;
			end
			S_LLO: begin
				mul_a = {16'd0, gain};
				mul_b = acc_q[55:24];
			end
			S_LHI, S_CMP: begin
				mul_a = {16'd0, gain};
				mul_b = {24'd0, acc_q[63:56]};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_comb begin
		lvl = 57'(lo_q) + {p_q[24:0], 32'd0};
		pwr = 57'({in_q.smooth_power, 16'd0});
		is_above = pwr > lvl;
		is_below = pwr < lvl;
		sum = 65'(base_q) + 65'(p_q);
		hold_eff = (hold_count_q < HOLD_MIN_C) ? HOLD_MIN_C : hold_count_q;
		max_eff = (max_count_q < MAX_MIN_C) ? MAX_MIN_C : max_count_q;
		dist_start = idx_q - start_q;
		dist_above = idx_q - above_q;
		above_new = is_above ? idx_q : above_q;
		peak_new = (in_q.inst_power > peak_q) ? in_q.inst_power : peak_q;
		out_free = !out_valid_q || out_ready;
	end

	always_comb begin
		rec = '0;
		rec.floor_level = acc_q[63:32];
		unique case (mode_q)
			M_ACTIVE: begin
				if (dmax_q || (hold_x_q && !is_above)) begin
					rec.pulse_done = 1'b1;
					rec.pulse_forced = dmax_q;
					rec.pulse_first = 48'(start_q);
					rec.pulse_last = 48'(above_new);
					rec.pulse_peak = peak_new;
				end else begin
					rec.detected = 1'b1;
				end
			end
			M_REARM: begin
				rec.detected = 1'b0;
			end
			default: begin
				rec.detected = is_above;
			end
		endcase
	end

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			mode_q <= M_IDLE;
			trigger_gain_q <= apd_pkg::TRIGGER_GAIN_RST;
			release_gain_q <= apd_pkg::RELEASE_GAIN_RST;
			floor_alpha_q <= apd_pkg::FLOOR_ALPHA_RST;
			hold_count_q <= apd_pkg::HOLD_COUNT_RST;
			max_count_q <= apd_pkg::MAX_COUNT_RST;
			out_valid_q <= 1'b0;
			acc_q <= '0;
			fv_q <= 1'b0;
			idx_q <= '0;
			start_q <= '0;
			above_q <= '0;
			peak_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					apd_pkg::CFG_TRIGGER_GAIN: trigger_gain_q <= cfg_data[15:0];
					apd_pkg::CFG_RELEASE_GAIN: release_gain_q <= cfg_data[15:0];
					apd_pkg::CFG_FLOOR_ALPHA:  floor_alpha_q <= cfg_data[31:0];
					apd_pkg::CFG_HOLD_COUNT:   hold_count_q <= cfg_data[23:0];
					apd_pkg::CFG_MAX_COUNT:    max_count_q <= cfg_data[23:0];
					default: ;
				endcase
			end
			if (out_valid_q && out_ready && (state_q != S_CMP)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						in_q <= in_data;
						state_q <= (mode_q == M_ACTIVE) ? S_LLO : S_MHI;
					end
				end
				S_MHI: begin
					if (!fv_q) begin
						// first sample seeds the floor
						acc_q <= {in_q.smooth_power, 32'd0};
						fv_q <= 1'b1;
						state_q <= S_LLO;
					end else begin
						state_q <= S_MLO;
					end
				end
				S_MLO: begin
					t_q <= p_q;
					state_q <= S_MP;
				end
				S_MP: begin
					t_q <= t_q + {32'd0, p_q[63:32]};
					state_q <= S_BASE;
				end
				S_BASE: begin
					base_q <= acc_q - t_q;
					state_q <= S_SUM;
				end
				S_SUM: begin
					acc_q <= sum[64] ? '1 : sum[63:0];
					state_q <= S_LLO;
				end
				S_LLO: begin
					dmax_q <= dist_start >= INDEX_BITS'(max_eff);
					state_q <= S_LHI;
				end
				S_LHI: begin
					lo_q <= p_q[47:0];
					hold_x_q <= dist_above > INDEX_BITS'(hold_eff);
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_q <= rec;
						unique case (mode_q)
							M_REARM: begin
								if (is_below) begin
									mode_q <= M_IDLE;
								end
							end
							M_ACTIVE: begin
								peak_q <= peak_new;
								above_q <= above_new;
								if (rec.pulse_done) begin
									mode_q <= dmax_q ? M_REARM : M_IDLE;
								end
							end
							default: begin
								if (is_above) begin
									mode_q <= M_ACTIVE;
									start_q <= idx_q;
									above_q <= idx_q;
									peak_q <= in_q.inst_power;
								end
							end
						endcase
						idx_q <= idx_q + INDEX_BITS'(1);
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== rtl/apd_checker.sv =====
`default_nettype none
`include "assert_macros.svh"
module apd_checker (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          in_valid,
	input wire logic          in_ready,
	input wire logic          out_valid,
	input wire logic          out_ready,
	input wire apd_pkg::out_t out_data
);

	logic rec_clear;

	// no pulse end means an all-zero record
	assign rec_clear = !out_data.pulse_forced && (out_data.pulse_first == 48'd0) &&
		(out_data.pulse_last == 48'd0) && (out_data.pulse_peak == 32'd0);

	`APD_ASSERT_ALWAYS(a_no_out_in_reset, !arst_n |=> !out_valid)
	`APD_ASSERT(a_out_held, out_valid && !out_ready |=> out_valid)
	`APD_ASSERT(a_busy_after_accept, in_valid && in_ready |=> !in_ready)
	`APD_ASSERT(a_done_excl, out_valid |-> !(out_data.detected && out_data.pulse_done))
	`APD_ASSERT(a_record_zero, out_valid && !out_data.pulse_done |-> rec_clear)

endmodule

bind adaptive_pulse_detector apd_checker u_apd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
`default_nettype wire
